@@ hw/rtl/nrstp_pkg.sv @@
package nrstp_pkg;

  localparam int MAX_DEPTH   = 32;
  localparam int NUM_REGIONS = 256;

  localparam int OPCODE_W = 2;
  localparam int REGION_W = 8;
  localparam int VAL_W    = 64;
  localparam int STATUS_W = 2;

  localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
  localparam int FRAME_AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int TAB_AW   = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;

  localparam int IN_FIELDS_W  = OPCODE_W + REGION_W + 2 * VAL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + REGION_W + 4 * VAL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ENTER = 2'd0,
    OP_EXIT  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic take;       // input transfer
    logic pop_rd;     // popped frame data available
    logic self_calc;  // self values
    logic commit;     // exit: table and parent update
    logic load_out;   // result register load
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic empty;
  } sts_t;

  function automatic logic rid_in_range(input logic [REGION_W-1:0] rid);
    return (32'(rid) < NUM_REGIONS);
  endfunction

endpackage

@@ hw/rtl/nrstp_ctrl.sv @@
module nrstp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  nrstp_pkg::sts_t   sts,
  output nrstp_pkg::cmd_t   cmd
);
  import nrstp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EX_RD,
    S_EX_CALC,
    S_EX_UPD,
    S_FIN
  } state_t;

  state_t state_r;
  logic   out_tvalid_r;
  logic   slot_free;
  logic   take;

  assign slot_free  = !out_tvalid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign take       = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd           = '0;
    cmd.take      = take;
    cmd.pop_rd    = (state_r == S_EX_RD);
    cmd.self_calc = (state_r == S_EX_CALC);
    cmd.commit    = (state_r == S_EX_UPD) && slot_free;
    cmd.load_out  = ((state_r == S_EX_UPD) || (state_r == S_FIN)) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.load_out)
        out_tvalid_r <= 1'b1;
      else if (out_tready)
        out_tvalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (take) begin
            if (sts.op == OP_EXIT && !sts.empty)
              state_r <= S_EX_RD;
            else
              state_r <= S_FIN;
          end
        end
        S_EX_RD:   state_r <= S_EX_CALC;
        S_EX_CALC: state_r <= S_EX_UPD;
        S_EX_UPD: begin
          if (slot_free)
            state_r <= S_IDLE;
        end
        S_FIN: begin
          if (slot_free)
            state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/nrstp_dp.sv @@
module nrstp_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nrstp_pkg::cmd_t                cmd,
  output nrstp_pkg::sts_t                sts,
  input  logic [nrstp_pkg::OPCODE_W-1:0] in_opcode,
  input  logic [nrstp_pkg::REGION_W-1:0] in_region_id,
  input  logic [nrstp_pkg::VAL_W-1:0]    in_time_now,
  input  logic [nrstp_pkg::VAL_W-1:0]    in_ops_now,
  output logic [nrstp_pkg::STATUS_W-1:0] res_status,
  output logic [nrstp_pkg::REGION_W-1:0] res_region,
  output logic [nrstp_pkg::VAL_W-1:0]    res_self_time,
  output logic [nrstp_pkg::VAL_W-1:0]    res_self_ops,
  output logic [nrstp_pkg::VAL_W-1:0]    res_sum_time,
  output logic [nrstp_pkg::VAL_W-1:0]    res_sum_ops
);
  import nrstp_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0]    start_time;
    logic [VAL_W-1:0]    start_ops;
    logic [REGION_W-1:0] region;
  } frame_t;

  typedef struct packed {
    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] o;
  } pair_t;

  frame_t frame_mem [MAX_DEPTH];
  pair_t  child_mem [MAX_DEPTH];
  pair_t  tab_mem   [NUM_REGIONS];

  frame_t frame_q_r;
  pair_t  child_q_r;
  pair_t  tab_q_r;

  logic [DEPTH_W-1:0]     depth_r;
  logic [NUM_REGIONS-1:0] valid_r;

  op_t                 op_r;
  status_t             status_r;
  logic [REGION_W-1:0] rid_r;
  logic [VAL_W-1:0]    time_r;
  logic [VAL_W-1:0]    ops_r;
  logic [FRAME_AW-1:0] top_r;

  logic [REGION_W-1:0] region_r;
  logic [VAL_W-1:0]    elapsed_r;
  logic [VAL_W-1:0]    total_r;
  logic [VAL_W-1:0]    child_t_r;
  logic [VAL_W-1:0]    child_o_r;
  logic [VAL_W-1:0]    self_t_r;
  logic [VAL_W-1:0]    self_o_r;

  logic [STATUS_W-1:0] res_status_r;
  logic [REGION_W-1:0] res_region_r;
  logic [VAL_W-1:0]    res_self_time_r;
  logic [VAL_W-1:0]    res_self_ops_r;
  logic [VAL_W-1:0]    res_sum_time_r;
  logic [VAL_W-1:0]    res_sum_ops_r;

  op_t                 in_op;
  logic                full;
  logic                empty;
  logic [DEPTH_W-1:0]  depth_m1;
  logic [FRAME_AW-1:0] push_idx;
  logic [FRAME_AW-1:0] top_idx;
  logic [FRAME_AW-1:0] parent_idx;
  logic                push;
  logic                pop;

  logic                fr_we;
  logic                ch_we;
  logic                ch_re;
  logic [FRAME_AW-1:0] ch_waddr;
  logic [FRAME_AW-1:0] ch_raddr;
  pair_t               ch_wdata;
  logic                tab_re;
  logic                tab_we;
  logic [TAB_AW-1:0]   tab_raddr;
  logic [TAB_AW-1:0]   ex_idx;
  logic                ex_in_range;
  logic                ex_valid;
  pair_t               ex_sum;
  logic [TAB_AW-1:0]   rd_idx;
  logic                rd_hit;

  assign in_op      = op_t'(in_opcode);
  assign full       = (depth_r >= DEPTH_W'(MAX_DEPTH));
  assign empty      = (depth_r == '0);
  assign depth_m1   = depth_r - DEPTH_W'(1);
  assign push_idx   = depth_r[FRAME_AW-1:0];
  assign top_idx    = depth_m1[FRAME_AW-1:0];
  assign parent_idx = top_r - FRAME_AW'(1);

  assign sts.op    = in_op;
  assign sts.empty = empty;

  assign push  = cmd.take && (in_op == OP_ENTER) && !full;
  assign pop   = cmd.take && (in_op == OP_EXIT) && !empty;
  assign fr_we = push;

  // child sums: zeroed on push, parent accumulates on exit commit
  assign ch_we    = push || (cmd.commit && (top_r != '0));
  assign ch_waddr = cmd.commit ? parent_idx : push_idx;
  assign ch_wdata = cmd.commit ? pair_t'{t: child_q_r.t + elapsed_r, o: child_q_r.o + total_r}
                               : '0;
  assign ch_re    = pop || cmd.pop_rd;
  assign ch_raddr = cmd.pop_rd ? parent_idx : top_idx;

  assign tab_re    = (cmd.take && (in_op == OP_READ)) || cmd.pop_rd;
  assign tab_raddr = cmd.pop_rd ? TAB_AW'(frame_q_r.region) : TAB_AW'(in_region_id);

  assign ex_idx      = TAB_AW'(region_r);
  assign ex_in_range = rid_in_range(region_r);
  assign ex_valid    = valid_r[ex_idx];
  assign ex_sum      = ex_valid ? pair_t'{t: tab_q_r.t + self_t_r, o: tab_q_r.o + self_o_r}
                                : pair_t'{t: self_t_r, o: self_o_r};
  assign tab_we      = cmd.commit && ex_in_range;

  assign rd_idx = TAB_AW'(rid_r);
  assign rd_hit = (op_r == OP_READ) && rid_in_range(rid_r) && valid_r[rd_idx];

  assign res_status    = res_status_r;
  assign res_region    = res_region_r;
  assign res_self_time = res_self_time_r;
  assign res_self_ops  = res_self_ops_r;
  assign res_sum_time  = res_sum_time_r;
  assign res_sum_ops   = res_sum_ops_r;

  always_ff @(posedge clk) begin
    if (fr_we)
      frame_mem[push_idx] <= '{start_time: in_time_now, start_ops: in_ops_now,
                               region: in_region_id};
    if (pop)
      frame_q_r <= frame_mem[top_idx];
    if (ch_we)
      child_mem[ch_waddr] <= ch_wdata;
    if (ch_re)
      child_q_r <= child_mem[ch_raddr];
    if (tab_we)
      tab_mem[ex_idx] <= ex_sum;
    if (tab_re)
      tab_q_r <= tab_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      valid_r <= '0;
    end else begin
      if (push)
        depth_r <= depth_r + DEPTH_W'(1);
      else if (pop)
        depth_r <= depth_m1;
      if (cmd.take && (in_op == OP_CLEAR))
        valid_r <= '0;
      else if (tab_we)
        valid_r[ex_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= in_op;
      rid_r  <= in_region_id;
      time_r <= in_time_now;
      ops_r  <= in_ops_now;
      top_r  <= top_idx;
      if (in_op == OP_ENTER && full)
        status_r <= ST_FULL;
      else if (in_op == OP_EXIT && empty)
        status_r <= ST_EMPTY;
      else
        status_r <= ST_DONE;
    end
    if (cmd.pop_rd) begin
      elapsed_r <= time_r - frame_q_r.start_time;
      total_r   <= ops_r - frame_q_r.start_ops;
      child_t_r <= child_q_r.t;
      child_o_r <= child_q_r.o;
      region_r  <= frame_q_r.region;
    end
    if (cmd.self_calc) begin
      self_t_r <= (elapsed_r > child_t_r) ? elapsed_r - child_t_r : '0;
      self_o_r <= (total_r > child_o_r) ? total_r - child_o_r : '0;
    end
    if (cmd.load_out) begin
      res_status_r <= status_r;
      if (cmd.commit) begin
        res_region_r    <= region_r;
        res_self_time_r <= self_t_r;
        res_self_ops_r  <= self_o_r;
        res_sum_time_r  <= ex_in_range ? ex_sum.t : '0;
        res_sum_ops_r   <= ex_in_range ? ex_sum.o : '0;
      end else begin
        res_region_r    <= (op_r == OP_ENTER || op_r == OP_READ) ? rid_r : '0;
        res_self_time_r <= '0;
        res_self_ops_r  <= '0;
        res_sum_time_r  <= rd_hit ? tab_q_r.t : '0;
        res_sum_ops_r   <= rd_hit ? tab_q_r.o : '0;
      end
    end
  end

endmodule

@@ hw/rtl/nested_region_self_time_profiler.sv @@
// Channel  Direction  Fields (tdata, lowest bit first)
// in_      slave      opcode[1:0] region_id[9:2] time_now[73:10] ops_now[137:74], pad to 144
// out_     master     status[1:0] out_region[9:2] self_time[73:10] self_ops[137:74]
//                     sum_time[201:138] sum_ops[265:202], pad to 272
//
// Enter, read, clear and an ignored exit go straight to the result; an exit that pops a frame
// steps through frame read, difference, saturating subtract, and table and parent update
// through single-port memories.
// One item in flight; next transfer accepted once the result sits in the output register.
// rst_n synchronous: empties the stack and invalidates the region table at once.
// A stalled result holds the block in its last state until out_tready.
module nested_region_self_time_profiler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // opcode, region_id, time_now, ops_now
  input  logic [nrstp_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status, out_region, self_time, self_ops, sum_time, sum_ops
  output logic [nrstp_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import nrstp_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [STATUS_W-1:0] res_status;
  logic [REGION_W-1:0] res_region;
  logic [VAL_W-1:0]    res_self_time;
  logic [VAL_W-1:0]    res_self_ops;
  logic [VAL_W-1:0]    res_sum_time;
  logic [VAL_W-1:0]    res_sum_ops;

  nrstp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  nrstp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_opcode     (in_tdata[OPCODE_W-1:0]),
    .in_region_id  (in_tdata[OPCODE_W +: REGION_W]),
    .in_time_now   (in_tdata[OPCODE_W+REGION_W +: VAL_W]),
    .in_ops_now    (in_tdata[OPCODE_W+REGION_W+VAL_W +: VAL_W]),
    .res_status    (res_status),
    .res_region    (res_region),
    .res_self_time (res_self_time),
    .res_self_ops  (res_self_ops),
    .res_sum_time  (res_sum_time),
    .res_sum_ops   (res_sum_ops)
  );

  assign out_tdata = {OUT_PAD_W'(0), res_sum_ops, res_sum_time, res_self_ops,
                      res_self_time, res_region, res_status};

endmodule
